// File: design/tlvd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tlvd_pkg;

    // Result kinds
    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_EMPTY   = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    // Error codes
    localparam logic [1:0] ERR_TOO_LONG   = 2'd0;
    localparam logic [1:0] ERR_BAD_TYPE   = 2'd1;
    localparam logic [1:0] ERR_BAD_LENGTH = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] CFG_MAX_FRAME = 3'd0;
    localparam logic [2:0] CFG_MAX_TEXT  = 3'd1;
    localparam logic [2:0] CFG_KEYSTROKE = 3'd2;
    localparam logic [2:0] CFG_PARAMS    = 3'd3;
    localparam logic [2:0] CFG_ROUND     = 3'd4;

    // Register reset values
    localparam logic [15:0] RST_MAX_FRAME = 16'd1000;
    localparam logic [9:0]  RST_MAX_TEXT  = 10'd900;
    localparam logic [9:0]  RST_KEYSTROKE = 10'd8;
    localparam logic [9:0]  RST_PARAMS    = 10'd16;
    localparam logic [9:0]  RST_ROUND     = 10'd8;

    typedef struct packed {
        logic [15:0] max_frame_length;
        logic [9:0]  max_text_length;
        logic [9:0]  keystroke_length;
        logic [9:0]  params_length;
        logic [9:0]  round_length;
    } cfg_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [3:0] msg_type;
        logic [7:0] payload_byte;
        logic       last_byte;
        logic [1:0] error_code;
    } result_t;

endpackage

`default_nettype wire

// File: design/tlvd_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module tlvd_cfg_regs
    import tlvd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        wr_en,
    input  wire logic [2:0]  wr_index,
    input  wire logic [15:0] wr_data,
    output cfg_t             cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                CFG_MAX_FRAME: cfg_next.max_frame_length = wr_data;
                CFG_MAX_TEXT:  cfg_next.max_text_length  = wr_data[9:0];
                CFG_KEYSTROKE: cfg_next.keystroke_length = wr_data[9:0];
                CFG_PARAMS:    cfg_next.params_length    = wr_data[9:0];
                CFG_ROUND:     cfg_next.round_length     = wr_data[9:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_frame_length <= RST_MAX_FRAME;
            cfg_reg.max_text_length  <= RST_MAX_TEXT;
            cfg_reg.keystroke_length <= RST_KEYSTROKE;
            cfg_reg.params_length    <= RST_PARAMS;
            cfg_reg.round_length     <= RST_ROUND;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// File: design/tlvd_parser.sv
`timescale 1ns / 1ps
`default_nettype none

module tlvd_parser
    import tlvd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire cfg_t       cfg,
    input  wire logic       step,
    input  wire logic [7:0] in_byte,
    output logic            res_valid,
    output result_t         res
);

    localparam logic [1:0] HDR_TYPE   = 2'd0;
    localparam logic [1:0] HDR_LEN_HI = 2'd1;
    localparam logic [1:0] HDR_LEN_LO = 2'd2;
    localparam logic [1:0] HDR_RSVD   = 2'd3;

    localparam logic [3:0] T_M = 4'd0;
    localparam logic [3:0] T_F = 4'd1;
    localparam logic [3:0] T_R = 4'd2;
    localparam logic [3:0] T_S = 4'd3;
    localparam logic [3:0] T_G = 4'd4;
    localparam logic [3:0] T_K = 4'd5;
    localparam logic [3:0] T_O = 4'd6;
    localparam logic [3:0] T_T = 4'd7;
    localparam logic [3:0] T_H = 4'd8;
    localparam logic [3:0] T_A = 4'd9;
    localparam logic [3:0] T_Q = 4'd10;
    localparam logic [3:0] T_P = 4'd11;
    localparam logic [3:0] T_U = 4'd12;

    localparam logic [15:0] WORD_LEN = 16'd4;

    // Returns {known, code}
    function automatic logic [4:0] decode_type(input logic [7:0] ch);
        logic [4:0] r;
        unique case (ch)
            8'h4D:   r = {1'b1, T_M};
            8'h46:   r = {1'b1, T_F};
            8'h52:   r = {1'b1, T_R};
            8'h53:   r = {1'b1, T_S};
            8'h47:   r = {1'b1, T_G};
            8'h4B:   r = {1'b1, T_K};
            8'h4F:   r = {1'b1, T_O};
            8'h54:   r = {1'b1, T_T};
            8'h48:   r = {1'b1, T_H};
            8'h41:   r = {1'b1, T_A};
            8'h51:   r = {1'b1, T_Q};
            8'h50:   r = {1'b1, T_P};
            8'h55:   r = {1'b1, T_U};
            default: r = 5'd0;
        endcase
        return r;
    endfunction

    function automatic logic is_text(input logic [3:0] code);
        return (code == T_M) || (code == T_G) || (code == T_U);
    endfunction

    logic        link_down_reg,  link_down_next;
    logic [1:0]  header_idx_reg, header_idx_next;
    logic        in_payload_reg, in_payload_next;
    logic [3:0]  type_code_reg,  type_code_next;
    logic        type_valid_reg, type_valid_next;
    logic [15:0] frame_len_reg,  frame_len_next;
    logic [15:0] bytes_left_reg, bytes_left_next;

    logic [4:0]  decoded;
    logic        len_ok;
    logic        last;

    assign decoded = decode_type(in_byte);
    assign last    = (bytes_left_reg == 16'd1);

    always_comb
    begin
        unique case (type_code_reg)
            T_M, T_G, T_U:
                len_ok = (frame_len_reg != 16'd0)
                      && (frame_len_reg <= {6'd0, cfg.max_text_length});
            T_F, T_T, T_H, T_A, T_Q:
                len_ok = (frame_len_reg == WORD_LEN);
            T_R, T_S:
                len_ok = (frame_len_reg == 16'd0);
            T_K:
                len_ok = (frame_len_reg == {6'd0, cfg.keystroke_length});
            T_O:
                len_ok = (frame_len_reg == {6'd0, cfg.round_length});
            T_P:
                len_ok = (frame_len_reg == {6'd0, cfg.params_length});
            default:
                len_ok = 1'b0;
        endcase
    end

    always_comb
    begin
        link_down_next  = link_down_reg;
        header_idx_next = header_idx_reg;
        in_payload_next = in_payload_reg;
        type_code_next  = type_code_reg;
        type_valid_next = type_valid_reg;
        frame_len_next  = frame_len_reg;
        bytes_left_next = bytes_left_reg;
        res_valid       = 1'b0;
        res             = '0;

        if (step && !link_down_reg)
        begin
            if (in_payload_reg)
            begin
                res_valid        = 1'b1;
                res.kind         = KIND_PAYLOAD;
                res.msg_type     = type_code_reg;
                res.payload_byte = (last && is_text(type_code_reg)) ? 8'd0 : in_byte;
                res.last_byte    = last;
                bytes_left_next  = bytes_left_reg - 16'd1;
                if (last)
                begin
                    in_payload_next = 1'b0;
                    header_idx_next = HDR_TYPE;
                end
            end
            else
            begin
                unique case (header_idx_reg)
                    HDR_TYPE:
                    begin
                        type_valid_next = decoded[4];
                        type_code_next  = decoded[3:0];
                        header_idx_next = HDR_LEN_HI;
                    end
                    HDR_LEN_HI:
                    begin
                        frame_len_next  = {in_byte, 8'd0};
                        header_idx_next = HDR_LEN_LO;
                    end
                    HDR_LEN_LO:
                    begin
                        frame_len_next  = {frame_len_reg[15:8], in_byte};
                        header_idx_next = HDR_RSVD;
                    end
                    HDR_RSVD:
                    begin
                        // Reserved byte ignored; header complete, run the checks
                        header_idx_next = HDR_TYPE;
                        res.msg_type    = type_code_reg;
                        priority if (frame_len_reg > cfg.max_frame_length)
                        begin
                            res_valid      = 1'b1;
                            res.kind       = KIND_ERROR;
                            res.error_code = ERR_TOO_LONG;
                            link_down_next = 1'b1;
                        end
                        else if (!type_valid_reg)
                        begin
                            res_valid      = 1'b1;
                            res.kind       = KIND_ERROR;
                            res.error_code = ERR_BAD_TYPE;
                            link_down_next = 1'b1;
                        end
                        else if (!len_ok)
                        begin
                            res_valid      = 1'b1;
                            res.kind       = KIND_ERROR;
                            res.error_code = ERR_BAD_LENGTH;
                            link_down_next = 1'b1;
                        end
                        else if (frame_len_reg == 16'd0)
                        begin
                            res_valid = 1'b1;
                            res.kind  = KIND_EMPTY;
                        end
                        else
                        begin
                            in_payload_next = 1'b1;
                            bytes_left_next = frame_len_reg;
                        end
                    end
                    default:
                    begin
                        header_idx_next = HDR_TYPE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_down_reg  <= 1'b0;
            header_idx_reg <= HDR_TYPE;
            in_payload_reg <= 1'b0;
            type_code_reg  <= 4'd0;
            type_valid_reg <= 1'b0;
            frame_len_reg  <= 16'd0;
            bytes_left_reg <= 16'd0;
        end
        else
        begin
            link_down_reg  <= link_down_next;
            header_idx_reg <= header_idx_next;
            in_payload_reg <= in_payload_next;
            type_code_reg  <= type_code_next;
            type_valid_reg <= type_valid_next;
            frame_len_reg  <= frame_len_next;
            bytes_left_reg <= bytes_left_next;
        end
    end

    a_error_latches: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.kind == KIND_ERROR) |=> link_down_reg)
        else $error("error result did not latch the disconnected state");

    a_silent_when_down: assert property (@(posedge clk) disable iff (!rst_n)
        link_down_reg |-> !res_valid)
        else $error("result produced while disconnected");

    a_payload_count: assert property (@(posedge clk) disable iff (!rst_n)
        in_payload_reg |-> (bytes_left_reg != 16'd0))
        else $error("payload phase with no bytes left");

    a_last_is_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.last_byte) |-> (res.kind == KIND_PAYLOAD))
        else $error("last marker on a non-payload result");

endmodule

`default_nettype wire

// File: design/tlvd_out_reg.sv
`timescale 1ns / 1ps
`default_nettype none

module tlvd_out_reg
    import tlvd_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    load,
    input  wire result_t din,
    output logic         space,
    output logic         valid,
    input  wire logic    ready,
    output result_t      dout
);

    logic    valid_reg, valid_next;
    result_t data_reg;

    assign space = !valid_reg || ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload holds while stalled
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= din;
        end
    end

    assign valid = valid_reg;
    assign dout  = data_reg;

endmodule

`default_nettype wire

// File: design/tlv_packet_deframer_core.sv
// Flow: a byte accepted is held in the input register until the result register has space;
//   its result, if any, is then loaded into the result register and offered on the master side.
// Throughput: one byte per cycle, set by the combinational header/payload step
//   between the input register and the result register; a held result stalls input.
// Reset: rst_n is asynchronous, active low; it reconnects the link, restarts header
//   collection and loads the configuration registers with their default values.
`timescale 1ns / 1ps
`default_nettype none

module tlv_packet_deframer_core
    import tlvd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data,

    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte

    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // [7:0] payload_byte, [9:8] error_code, rest 0
    output logic             m_axis_tlast,   // last_byte
    output logic [5:0]       m_axis_tuser    // [1:0] kind, [5:2] msg_type
);

    cfg_t       cfg;
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       space;
    logic       step;
    logic       res_valid;
    result_t    res;
    result_t    out_res;

    assign cfg_ready = 1'b1;

    tlvd_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // Advance the input register whenever the result register can take the outcome
    assign step          = in_valid_reg && space;
    assign s_axis_tready = !in_valid_reg || space;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_valid_next = 1'b1;
        end
        else if (step)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_byte_reg <= s_axis_tdata;
        end
    end

    tlvd_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .step      (step),
        .in_byte   (in_byte_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    tlvd_out_reg u_out (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (res_valid),
        .din   (res),
        .space (space),
        .valid (m_axis_tvalid),
        .ready (m_axis_tready),
        .dout  (out_res)
    );

    assign m_axis_tdata = {6'd0, out_res.error_code, out_res.payload_byte};
    assign m_axis_tlast = out_res.last_byte;
    assign m_axis_tuser = {out_res.msg_type, out_res.kind};

endmodule

`default_nettype wire
